/* src/plb_pkg.sv */
// Package: operation and status codes and the control bundle broadcast to the cells.
`timescale 1ns / 1ps
`default_nettype none
package plb_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_AT    = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* src/plb_cell.sv */
// One storage cell of the list: holds one byte and moves it toward either neighbor.
`timescale 1ns / 1ps
`default_nettype none
module plb_cell #(
    parameter int unsigned IW  = 4,
    parameter int unsigned IDX = 0
) (
    input  wire logic                      i_clk,
    input  wire plb_pkg::t_cell_ctl        i_ctl,
    input  wire logic [IW-1:0]             i_idx,
    input  wire logic [plb_pkg::DATA_W-1:0] i_left,
    input  wire logic [plb_pkg::DATA_W-1:0] i_right,
    output logic [plb_pkg::DATA_W-1:0]     o_data
);
    import plb_pkg::*;

    logic [IW-1:0]     my_idx;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    assign my_idx = IW'(IDX);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (my_idx == i_idx) begin
                n_data = i_ctl.value;
            end else if (my_idx > i_idx) begin
                n_data = i_left;
            end
        end else if (i_ctl.rem) begin
            // close the gap: every cell from the removed place on takes its right neighbor
            if (my_idx >= i_idx) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

/* src/positional_list_buffer_core.sv */
// Top level: ordered byte list built from a row of shifting cells.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY bytes with insert and remove at the front, the back or a
// 1-based position. Every accepted item yields one result in the next cycle, and a new item
// is taken in every cycle as long as the result register is empty or being drained: all
// cells shift together in the cycle of the transfer. A failed operation (full, empty,
// position out of range) leaves the contents alone and reports it in the status. Nothing
// needs clearing after reset; only the fill count and the output valid flag are reset.
module positional_list_buffer_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [plb_pkg::OP_W-1:0]      i_operation,
    input  wire logic [plb_pkg::POS_W-1:0]     i_position,
    input  wire logic [plb_pkg::DATA_W-1:0]    i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [plb_pkg::DATA_W-1:0]         o_removed_value,
    output logic [plb_pkg::STATUS_W-1:0]       o_status,
    output logic [plb_pkg::COUNT_W-1:0]        o_count
);
    import plb_pkg::*;

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned WW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_removed;
    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_count_out;

    logic [WW-1:0]     cnt_w;
    logic [WW-1:0]     pos_w;
    logic [WW-1:0]     tgt_w;
    logic [WW-1:0]     n_count_w;
    logic [IW-1:0]     tgt_idx;
    logic              ins_ok;
    logic              rem_ok;
    t_status           status;
    logic              accept;
    t_cell_ctl         ctl;
    logic [DATA_W-1:0] rd_value;

    logic [DATA_W-1:0] cell_data [CAPACITY];

    assign cnt_w = WW'(r_count);
    assign pos_w = WW'(i_position);

    // decode the operation against the current fill
    always_comb begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        status = ST_OK;
        tgt_w  = '0;
        case (t_op'(i_operation))
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (cnt_w >= WW'(CAPACITY)) begin
                    status = ST_FULL;
                end else if (t_op'(i_operation) == OP_INS_FRONT) begin
                    ins_ok = 1'b1;
                end else if (t_op'(i_operation) == OP_INS_BACK) begin
                    ins_ok = 1'b1;
                    tgt_w  = cnt_w;
                end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
                    status = ST_RANGE;
                end else begin
                    ins_ok = 1'b1;
                    tgt_w  = pos_w - WW'(1);
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (cnt_w == '0) begin
                    status = ST_EMPTY;
                end else if (t_op'(i_operation) == OP_REM_FRONT) begin
                    rem_ok = 1'b1;
                end else if (t_op'(i_operation) == OP_REM_BACK) begin
                    rem_ok = 1'b1;
                    tgt_w  = cnt_w - WW'(1);
                end else if (pos_w == '0 || pos_w > cnt_w) begin
                    status = ST_RANGE;
                end else begin
                    rem_ok = 1'b1;
                    tgt_w  = pos_w - WW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign tgt_idx    = tgt_w[IW-1:0];
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign ctl.ins   = accept && ins_ok;
    assign ctl.rem   = accept && rem_ok;
    assign ctl.value = i_value;

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    assign n_count_w = WW'(n_count);

    // select the byte at the target place from the row
    always_comb begin
        rd_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (tgt_idx == IW'(k)) begin
                rd_value = rd_value | cell_data[k];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = i_value;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[g];
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        plb_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_idx   (tgt_idx),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, held while the output is stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed   <= rem_ok ? rd_value : '0;
            r_status    <= status;
            r_count_out <= n_count_w[COUNT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_count         = r_count_out;

endmodule
`default_nettype wire

/* src/plb_checker.sv */
// Checker on the ports of the list buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module plb_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [plb_pkg::DATA_W-1:0]    o_removed_value,
    input wire logic [plb_pkg::STATUS_W-1:0]  o_status,
    input wire logic [plb_pkg::COUNT_W-1:0]   o_count
);
    import plb_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_removed_value)
            && $stable(o_status) && $stable(o_count))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> 32'(o_count) == CAPACITY)
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_count == '0 && o_removed_value == '0)
        else $error("empty reported with entries held");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_count) <= CAPACITY)
        else $error("count above capacity");

endmodule

bind positional_list_buffer_core plb_checker #(.CAPACITY(CAPACITY)) u_plb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_removed_value (o_removed_value),
    .o_status        (o_status),
    .o_count         (o_count)
);
`default_nettype wire
